FILE: rtl/life_automaton_torus_step_top_defines.svh
// assertion macros shared by the checker of the life automaton block
// depends on clk and rst_n being visible where a macro is used
`ifndef LIFE_AUTOMATON_TORUS_STEP_TOP_DEFINES_SVH
`define LIFE_AUTOMATON_TORUS_STEP_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define LAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define LAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// same-cycle implication, also checked around reset
`define LAT_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/lat_pkg.sv
// constants, types and helpers of the toroidal life automaton
// used by every other file of the block but the assertion macro header
package lat_pkg;

  localparam int GRID_ROWS = 42;
  localparam int GRID_COLS = 80;

  localparam int OP_W   = 2;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int NBR_W  = 4;

  localparam int ROW_AW = $clog2(GRID_ROWS);
  localparam int COL_IW = $clog2(GRID_COLS);
  localparam int CNT_W  = $clog2(GRID_ROWS + 2);

  localparam logic [CNT_W-1:0]  CLR_LAST  = CNT_W'(GRID_ROWS - 1);
  localparam logic [CNT_W-1:0]  COPY_LAST = CNT_W'(GRID_ROWS - 1);
  localparam logic [CNT_W-1:0]  GEN_LAST  = CNT_W'(GRID_ROWS + 1);
  localparam logic [CNT_W-1:0]  GEN_WR_FIRST = CNT_W'(2);
  localparam logic [CNT_W-1:0]  GEN_ROW0 = CNT_W'(1);
  localparam logic [ROW_AW-1:0] LAST_ROW_ADDR = ROW_AW'(GRID_ROWS - 1);

  localparam logic [CHAR_W-1:0] CHAR_BASE   = CHAR_W'(161);
  localparam logic [NBR_W-1:0]  BIRTH_CNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0]  SURVIVE_CNT = NBR_W'(2);

  typedef logic [GRID_COLS-1:0] row_t;
  typedef logic [ROW_AW-1:0]    raddr_t;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTORE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_GEN,
    ST_COPY,
    ST_BLK0,
    ST_BLK1,
    ST_RESP
  } state_t;

  typedef struct packed {
    raddr_t rd_addr;
    logic   live_we;
    logic   saved_we;
    raddr_t wr_addr;
    row_t   live_wdata;
    row_t   saved_wdata;
  } mem_req_t;

  typedef struct packed {
    row_t up;
    row_t cur;
    row_t dn;
  } rule_win_t;

  function automatic logic row_ok(input logic [ROW_W-1:0] r);
    return 32'(r) < GRID_ROWS;
  endfunction

  function automatic logic col_ok(input logic [COL_W-1:0] c);
    return 32'(c) < GRID_COLS;
  endfunction

  function automatic logic blk_row_ok(input logic [ROW_W-1:0] r);
    return (32'(r) << 1) < GRID_ROWS;
  endfunction

  function automatic logic blk_row1_ok(input logic [ROW_W-1:0] r);
    return ((32'(r) << 1) + 32'd1) < GRID_ROWS;
  endfunction

  function automatic logic blk_col_ok(input logic [COL_W-1:0] c);
    return (32'(c) << 1) < GRID_COLS;
  endfunction

  function automatic logic blk_col1_ok(input logic [COL_W-1:0] c);
    return ((32'(c) << 1) + 32'd1) < GRID_COLS;
  endfunction

endpackage

FILE: rtl/lat_in_if.sv
// request channel of the life automaton: op, cell position and value
// depends on lat_pkg
interface lat_in_if;
  import lat_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             cell_value;

  modport source (output valid, output op, output row, output col, output cell_value,
                  input ready);
  modport sink (input valid, input op, input row, input col, input cell_value,
                output ready);
endinterface

FILE: rtl/lat_out_if.sv
// result channel of the life automaton: block character and done flag
// depends on lat_pkg
interface lat_out_if;
  import lat_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] block_char;
  logic              done_res;

  modport source (output valid, output block_char, output done_res, input ready);
  modport sink (input valid, input block_char, input done_res, output ready);
endinterface

FILE: rtl/life_automaton_torus_step_top.sv
// top level of the toroidal life automaton (B3/S23)
// depends on lat_pkg, lat_in_if, lat_out_if, lat_mem, lat_rule, lat_seq
//
// One request at a time, each answered by exactly one result; a result waits in
// an output register while the next request is taken. After reset a clearing
// pass over all GRID_ROWS rows zeroes both grids, with no request accepted.
// The live grid memory moves one whole row per cycle through its single read
// port; advance evaluates a full row per cycle from a three-row window and
// writes the new row back in place two rows behind the read.
module life_automaton_torus_step_top (
  input  logic      clk,
  input  logic      rst_n,
  lat_in_if.sink    in_ch,
  lat_out_if.source out_ch
);
  import lat_pkg::*;

  mem_req_t  mem_req;
  row_t      live_rd;
  row_t      saved_rd;
  rule_win_t rule_win;
  row_t      rule_nxt;

  lat_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .mem_req  (mem_req),
    .live_rd  (live_rd),
    .saved_rd (saved_rd),
    .rule_win (rule_win),
    .rule_nxt (rule_nxt)
  );

  lat_mem u_mem (
    .clk      (clk),
    .req      (mem_req),
    .live_rd  (live_rd),
    .saved_rd (saved_rd)
  );

  lat_rule u_rule (
    .win (rule_win),
    .nxt (rule_nxt)
  );
endmodule

FILE: rtl/lat_mem.sv
// row-wide memories for the live grid and the saved pattern
// one write and one registered read per cycle each; depends on lat_pkg
module lat_mem (
  input  logic              clk,
  input  lat_pkg::mem_req_t req,
  output lat_pkg::row_t     live_rd,
  output lat_pkg::row_t     saved_rd
);
  import lat_pkg::*;

  row_t live_mem  [GRID_ROWS];
  row_t saved_mem [GRID_ROWS];
  row_t live_rd_r;
  row_t saved_rd_r;

  always_ff @(posedge clk) begin
    if (req.live_we) begin
      live_mem[req.wr_addr] <= req.live_wdata;
    end
    live_rd_r <= live_mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.saved_we) begin
      saved_mem[req.wr_addr] <= req.saved_wdata;
    end
    saved_rd_r <= saved_mem[req.rd_addr];
  end

  assign live_rd  = live_rd_r;
  assign saved_rd = saved_rd_r;
endmodule

FILE: rtl/lat_rule.sv
// next state of one whole row from the rows above, at and below it
// wrap-around columns; depends on lat_pkg
module lat_rule (
  input  lat_pkg::rule_win_t win,
  output lat_pkg::row_t      nxt
);
  import lat_pkg::*;

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
    localparam int LF = (c + GRID_COLS - 1) % GRID_COLS;
    localparam int RT = (c + 1) % GRID_COLS;
    logic [NBR_W-1:0] nbr;

    assign nbr = NBR_W'(win.up[LF]) + NBR_W'(win.up[c]) + NBR_W'(win.up[RT])
               + NBR_W'(win.cur[LF]) + NBR_W'(win.cur[RT])
               + NBR_W'(win.dn[LF]) + NBR_W'(win.dn[c]) + NBR_W'(win.dn[RT]);
    assign nxt[c] = (nbr == BIRTH_CNT) || (win.cur[c] && (nbr == SURVIVE_CNT));
  end
endmodule

FILE: rtl/lat_seq.sv
// sequencer: decodes requests, drives the grid memories row by row,
// keeps the generation row window and the result register; depends on lat_pkg
module lat_seq (
  input  logic               clk,
  input  logic               rst_n,
  lat_in_if.sink             in_ch,
  lat_out_if.source          out_ch,
  output lat_pkg::mem_req_t  mem_req,
  input  lat_pkg::row_t      live_rd,
  input  lat_pkg::row_t      saved_rd,
  output lat_pkg::rule_win_t rule_win,
  input  lat_pkg::row_t      rule_nxt
);
  import lat_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic              val_r;
  row_t              up_r;
  row_t              cur_r;
  row_t              row0_r;
  logic [1:0]        top_r;
  logic [CHAR_W-1:0] res_char_r;
  logic              res_done_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_done_r;

  logic              in_acc;
  logic              slot_free;
  op_t               in_op;
  logic [COL_IW-1:0] cell_idx;
  logic [COL_IW-1:0] blk_idx0;
  logic [COL_IW-1:0] blk_idx1;
  logic [1:0]        pair_bits;

  assign in_op     = op_t'(in_ch.op);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign cell_idx  = COL_IW'(col_r);
  assign blk_idx0  = COL_IW'({col_r, 1'b0});
  assign blk_idx1  = COL_IW'({col_r, 1'b1});

  // two horizontally adjacent cells of the block, right one dead past the edge
  assign pair_bits = {blk_col1_ok(col_r) ? live_rd[blk_idx1] : 1'b0, live_rd[blk_idx0]};

  // three-row window for the rule, row 0 wraps in below the last row
  assign rule_win = '{up: up_r, cur: cur_r, dn: (cnt_r == GEN_LAST) ? row0_r : live_rd};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (cnt_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_WRITE:   state_nxt = (row_ok(in_ch.row) && col_ok(in_ch.col)) ? ST_CELL
                                                                              : ST_RESP;
            OP_STEP:    state_nxt = ST_GEN;
            OP_RESTORE: state_nxt = ST_COPY;
            OP_READ:    state_nxt = (blk_row_ok(in_ch.row) && blk_col_ok(in_ch.col)) ? ST_BLK0
                                                                                      : ST_RESP;
          endcase
        end
      end
      ST_CELL: state_nxt = ST_RESP;
      ST_GEN:  if (cnt_r == GEN_LAST) state_nxt = ST_RESP;
      ST_COPY: if (cnt_r == COPY_LAST) state_nxt = ST_RESP;
      ST_BLK0: state_nxt = ST_BLK1;
      ST_BLK1: state_nxt = ST_RESP;
      ST_RESP: if (slot_free) state_nxt = ST_IDLE;
    endcase
  end

  // memory drive
  always_comb begin
    mem_req             = '0;
    mem_req.wr_addr     = ROW_AW'(cnt_r);
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.live_we  = 1'b1;
        mem_req.saved_we = 1'b1;
      end
      ST_IDLE: begin
        unique case (in_op)
          OP_WRITE:   mem_req.rd_addr = ROW_AW'(in_ch.row);
          OP_STEP:    mem_req.rd_addr = LAST_ROW_ADDR;
          OP_RESTORE: mem_req.rd_addr = '0;
          OP_READ:    mem_req.rd_addr = ROW_AW'({in_ch.row, 1'b0});
        endcase
      end
      ST_CELL: begin
        mem_req.live_we               = 1'b1;
        mem_req.saved_we              = 1'b1;
        mem_req.wr_addr               = ROW_AW'(row_r);
        mem_req.live_wdata            = live_rd;
        mem_req.live_wdata[cell_idx]  = val_r;
        mem_req.saved_wdata           = saved_rd;
        mem_req.saved_wdata[cell_idx] = val_r;
      end
      ST_GEN: begin
        mem_req.rd_addr    = ROW_AW'(cnt_r);
        mem_req.live_we    = (cnt_r >= GEN_WR_FIRST);
        mem_req.wr_addr    = ROW_AW'(cnt_r - GEN_WR_FIRST);
        mem_req.live_wdata = rule_nxt;
      end
      ST_COPY: begin
        mem_req.rd_addr    = ROW_AW'(cnt_r + CNT_W'(1));
        mem_req.live_we    = 1'b1;
        mem_req.live_wdata = saved_rd;
      end
      ST_BLK0: mem_req.rd_addr = ROW_AW'({row_r, 1'b1});
      ST_BLK1: mem_req.rd_addr = ROW_AW'({row_r, 1'b1});
      ST_RESP: mem_req.rd_addr = '0;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        cnt_r <= '0;
      end else if (state_r == ST_CLEAR || state_r == ST_GEN || state_r == ST_COPY) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (state_r == ST_RESP && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      row_r      <= in_ch.row;
      col_r      <= in_ch.col;
      val_r      <= in_ch.cell_value;
      res_char_r <= '0;
      unique case (in_op)
        OP_WRITE:   res_done_r <= row_ok(in_ch.row) && col_ok(in_ch.col);
        OP_STEP:    res_done_r <= 1'b1;
        OP_RESTORE: res_done_r <= 1'b1;
        OP_READ:    res_done_r <= blk_row_ok(in_ch.row) && blk_col_ok(in_ch.col);
      endcase
    end
    if (state_r == ST_GEN) begin
      up_r  <= cur_r;
      cur_r <= live_rd;
      if (cnt_r == GEN_ROW0) begin
        row0_r <= live_rd;
      end
    end
    if (state_r == ST_BLK0) begin
      top_r <= pair_bits;
    end
    if (state_r == ST_BLK1) begin
      res_char_r <= CHAR_BASE
                  + CHAR_W'({blk_row1_ok(row_r) ? pair_bits : 2'b00, top_r});
    end
    if (state_r == ST_RESP && slot_free) begin
      out_char_r <= res_char_r;
      out_done_r <= res_done_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.block_char = out_char_r;
  assign out_ch.done_res   = out_done_r;
endmodule

FILE: rtl/lat_chk.sv
// port-level checker for the life automaton, bound to the top level
// depends on lat_pkg and life_automaton_torus_step_top_defines.svh
`include "life_automaton_torus_step_top_defines.svh"

module lat_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lat_pkg::CHAR_W-1:0] out_block_char,
  input logic                       out_done_res
);
  import lat_pkg::*;

  localparam logic [CHAR_W-1:0] CHAR_TOP = CHAR_BASE + CHAR_W'(15);

  `LAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `LAT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken early")
  `LAT_ASSERT_NOW(a_fail_no_char, out_valid && !out_done_res, out_block_char == '0, "char on failed request")
  `LAT_ASSERT_NOW(a_char_range, out_valid && (out_block_char != '0), out_done_res && (out_block_char >= CHAR_BASE) && (out_block_char <= CHAR_TOP), "block char out of range")
  `LAT_ASSERT_ALWAYS(a_clear_pass, $rose(rst_n), !in_ready, "request taken before clearing pass")
endmodule

bind life_automaton_torus_step_top lat_chk u_lat_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_block_char (out_ch.block_char),
  .out_done_res   (out_ch.done_res)
);

FILE: tb/tb_top.sv
// self-checking bench for the toroidal life automaton block
// predicts every result from its own copy of the grid and saved pattern
// depends on lat_pkg, lat_in_if, lat_out_if and life_automaton_torus_step_top
module tb_top;
  import lat_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int PHASE_ITEMS     = 450;

  typedef struct packed {
    logic [CHAR_W-1:0] block_char;
    logic              done_res;
  } block_result_t;

  class life_scoreboard;
    bit [GRID_COLS-1:0] live_rows [GRID_ROWS];
    bit [GRID_COLS-1:0] saved_rows [GRID_ROWS];
    block_result_t      pending_q [$];
    int                 mismatch_count;
    int                 results_checked;
    int                 op_count [4];

    function int cell_bit(int r, int c);
      if (r >= GRID_ROWS || c >= GRID_COLS) begin
        return 0;
      end
      return int'(live_rows[r][c]);
    endfunction

    function void advance_generation();
      bit [GRID_COLS-1:0] next_rows [GRID_ROWS];
      int nbrs;
      for (int r = 0; r < GRID_ROWS; r++) begin
        for (int c = 0; c < GRID_COLS; c++) begin
          nbrs = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0) begin
                nbrs += cell_bit((r + dr + GRID_ROWS) % GRID_ROWS,
                                 (c + dc + GRID_COLS) % GRID_COLS);
              end
            end
          end
          if (live_rows[r][c]) begin
            next_rows[r][c] = (nbrs == 2 || nbrs == 3);
          end else begin
            next_rows[r][c] = (nbrs == 3);
          end
        end
      end
      live_rows = next_rows;
    endfunction

    function void note_request(op_t op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                               logic cell_value);
      block_result_t exp_res;
      int r;
      int c;
      exp_res = '0;
      op_count[op]++;
      case (op)
        OP_WRITE: begin
          if (row < GRID_ROWS && col < GRID_COLS) begin
            live_rows[row][col]  = cell_value;
            saved_rows[row][col] = cell_value;
            exp_res.done_res = 1'b1;
          end
        end
        OP_STEP: begin
          advance_generation();
          exp_res.done_res = 1'b1;
        end
        OP_RESTORE: begin
          live_rows = saved_rows;
          exp_res.done_res = 1'b1;
        end
        default: begin
          r = 2 * int'(row);
          c = 2 * int'(col);
          if (r < GRID_ROWS && c < GRID_COLS) begin
            exp_res.block_char = CHAR_W'(int'(CHAR_BASE) + cell_bit(r, c)
                                 + 2 * cell_bit(r, c + 1) + 4 * cell_bit(r + 1, c)
                                 + 8 * cell_bit(r + 1, c + 1));
            exp_res.done_res = 1'b1;
          end
        end
      endcase
      pending_q.push_back(exp_res);
    endfunction

    function void check_result(logic [CHAR_W-1:0] block_char, logic done_res);
      block_result_t exp_res;
      if (pending_q.size() == 0) begin
        $error("result with no request pending: block_char %0d done_res %0d",
               block_char, done_res);
        mismatch_count++;
        return;
      end
      exp_res = pending_q.pop_front();
      results_checked++;
      if (block_char !== exp_res.block_char) begin
        $error("block_char mismatch: expected %0d, got %0d", exp_res.block_char, block_char);
        mismatch_count++;
      end
      if (done_res !== exp_res.done_res) begin
        $error("done_res mismatch: expected %0d, got %0d", exp_res.done_res, done_res);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lat_in_if  in_ch ();
  lat_out_if out_ch ();

  life_automaton_torus_step_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  life_scoreboard life_sb = new();

  int requests_sent;
  int sender_idle_pct;
  int receiver_stall_pct;
  bit hold_off_req;

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      life_sb.check_result(out_ch.block_char, out_ch.done_res);
    end
  end

  task automatic send_request(op_t op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                              logic cell_value);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.row        <= row;
    in_ch.col        <= col;
    in_ch.cell_value <= cell_value;
    do @(posedge clk); while (!in_ch.ready);
    life_sb.note_request(op, row, col, cell_value);
    requests_sent++;
  endtask

  task automatic run_phase(int n_items, int idle_pct, int stall_pct, bit with_hold_off);
    int start_count;
    int kind;
    int r0;
    int c0;
    start_count = requests_sent;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    hold_off_req = with_hold_off;
    while (requests_sent - start_count < n_items) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        // small pattern around an anchor, then a few generations or restores with nearby reads
        r0 = $urandom_range(GRID_ROWS - 1);
        c0 = $urandom_range(GRID_COLS - 1);
        if ($urandom_range(9) == 0) begin
          send_request(OP_RESTORE, ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
        end
        repeat ($urandom_range(3, 12)) begin
          send_request(OP_WRITE, ROW_W'((r0 + $urandom_range(5)) % GRID_ROWS),
                       COL_W'((c0 + $urandom_range(5)) % GRID_COLS),
                       $urandom_range(99) < 80);
        end
        repeat ($urandom_range(1, 4)) begin
          send_request(($urandom_range(9) == 0) ? OP_RESTORE : OP_STEP,
                       ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
          repeat ($urandom_range(1, 3)) begin
            send_request(OP_READ, ROW_W'(((r0 + $urandom_range(7)) % GRID_ROWS) / 2),
                         COL_W'(((c0 + $urandom_range(7)) % GRID_COLS) / 2),
                         1'($urandom));
          end
        end
      end else if (kind < 80) begin
        if ($urandom_range(1)) begin
          send_request(OP_READ, ROW_W'($urandom_range(GRID_ROWS / 2 - 1)),
                       COL_W'($urandom_range(GRID_COLS / 2 - 1)), 1'($urandom));
        end else begin
          send_request(OP_WRITE, ROW_W'($urandom_range(GRID_ROWS - 1)),
                       COL_W'($urandom_range(GRID_COLS - 1)), 1'($urandom));
        end
      end else begin
        // unconstrained fields, mostly out-of-grid positions
        send_request(op_t'($urandom_range(3)), ROW_W'($urandom), COL_W'($urandom),
                     1'($urandom));
      end
    end
  endtask

  initial begin
    int wait_cycles;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_WRITE;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.cell_value = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // cleared grid, edge blocks and out-of-grid reads
    send_request(OP_READ, 6'd0, 7'd0, 1'b0);
    send_request(OP_READ, 6'd20, 7'd39, 1'b0);
    send_request(OP_READ, 6'd21, 7'd0, 1'b0);
    send_request(OP_READ, 6'd0, 7'd40, 1'b0);
    send_request(OP_READ, 6'd63, 7'd127, 1'b1);
    // four corners form a still life across the wrap
    send_request(OP_WRITE, 6'd0, 7'd0, 1'b1);
    send_request(OP_WRITE, 6'd0, 7'd79, 1'b1);
    send_request(OP_WRITE, 6'd41, 7'd0, 1'b1);
    send_request(OP_WRITE, 6'd41, 7'd79, 1'b1);
    send_request(OP_WRITE, 6'd42, 7'd0, 1'b1);
    send_request(OP_WRITE, 6'd0, 7'd80, 1'b1);
    send_request(OP_WRITE, 6'd63, 7'd127, 1'b1);
    send_request(OP_READ, 6'd0, 7'd0, 1'b0);
    send_request(OP_READ, 6'd20, 7'd39, 1'b0);
    send_request(OP_STEP, 6'd63, 7'd127, 1'b1);
    send_request(OP_READ, 6'd0, 7'd39, 1'b0);
    send_request(OP_READ, 6'd20, 7'd0, 1'b0);
    // blinker
    send_request(OP_WRITE, 6'd10, 7'd10, 1'b1);
    send_request(OP_WRITE, 6'd10, 7'd11, 1'b1);
    send_request(OP_WRITE, 6'd10, 7'd12, 1'b1);
    send_request(OP_STEP, 6'd0, 7'd0, 1'b0);
    send_request(OP_READ, 6'd5, 7'd5, 1'b0);
    send_request(OP_RESTORE, 6'd0, 7'd0, 1'b0);
    send_request(OP_READ, 6'd5, 7'd5, 1'b0);
    send_request(OP_WRITE, 6'd0, 7'd0, 1'b0);

    run_phase(PHASE_ITEMS, 0, 0, 1'b1);
    run_phase(PHASE_ITEMS, 76, 0, 1'b0);
    run_phase(PHASE_ITEMS, 0, 76, 1'b0);
    run_phase(PHASE_ITEMS, 10, 10, 1'b0);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (life_sb.pending_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (life_sb.pending_q.size() != 0) begin
      $error("%0d expected results never arrived", life_sb.pending_q.size());
      life_sb.mismatch_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("requests: %0d writes, %0d generations, %0d restores, %0d block reads",
             life_sb.op_count[OP_WRITE], life_sb.op_count[OP_STEP],
             life_sb.op_count[OP_RESTORE], life_sb.op_count[OP_READ]);
    $display("%0d results checked across four idle/stall mixes and one long output hold-off",
             life_sb.results_checked);
    if (life_sb.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
